### rtl/histogram_delay_offset_estimator_top_defines.svh
// Assertion macros used by the checker file.
`ifndef HISTOGRAM_DELAY_OFFSET_ESTIMATOR_TOP_DEFINES_SVH
`define HISTOGRAM_DELAY_OFFSET_ESTIMATOR_TOP_DEFINES_SVH

// Clocked check, switched off while reset is asserted
`define HDOE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked check that also holds during reset
`define HDOE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/hdoe_pkg.sv
package hdoe_pkg;

  // Sizing
  localparam int NUM_BINS      = 600;
  localparam int NUM_CLIENTS   = 32;
  localparam int BIN_FRAC_BITS = 8;

  localparam int BIN_W  = $clog2(NUM_BINS);
  localparam int IDX_W  = $clog2(NUM_BINS + 1);
  localparam int CL_W   = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int ADDR_W = $clog2(NUM_CLIENTS * NUM_BINS);
  localparam int CNT_W  = 20;
  localparam int TIME_W = 31;
  localparam int CFG_W  = 11;

  localparam logic [CNT_W-1:0] BIN_MAX = '1;
  localparam logic [CNT_W-1:0] BIN_ONE = CNT_W'(1 << BIN_FRAC_BITS);

  typedef enum logic [1:0] {
    CMD_MOVE  = 2'd0,
    CMD_DECAY = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_CLEAR = 2'd3
  } hdoe_cmd_e;

  typedef enum logic [1:0] {
    CFG_USER_OFFSET = 2'd0,
    CFG_MAX_SHIFT   = 2'd1,
    CFG_HOLD        = 2'd2
  } hdoe_cfg_e;

  typedef enum logic [4:0] {
    S_IDLE, S_SETUP, S_WIPE, S_MOVE_PRIME, S_MOVE, S_DECAY_PRIME, S_DECAY,
    S_BACK_PRIME, S_BACK, S_FWD_PRIME, S_FWD, S_SCAN_PRIME, S_SCAN, S_DRAIN,
    S_FIN1, S_FIN2, S_FIN3, S_OUT
  } hdoe_state_e;

endpackage

### rtl/hdoe_in_if.sv
interface hdoe_in_if;
  import hdoe_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [5:0]        client;
  logic [TIME_W-1:0] time_now;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W-1:0] end_time;
  logic [TIME_W-1:0] command_time;

  modport source (output valid, cmd, client, time_now, start_time, end_time,
                  command_time, input ready);
  modport sink   (input valid, cmd, client, time_now, start_time, end_time,
                  command_time, output ready);
endinterface

### rtl/hdoe_out_if.sv
interface hdoe_out_if;
  import hdoe_pkg::*;

  logic               valid;
  logic               ready;
  logic signed [11:0] offset_ms;
  logic signed [10:0] optimal_offset_ms;
  logic               active;

  modport source (output valid, offset_ms, optimal_offset_ms, active, input ready);
  modport sink   (input valid, offset_ms, optimal_offset_ms, active, output ready);
endinterface

### rtl/histogram_delay_offset_estimator_top.sv
// Per-client delay-offset estimator over a decaying coverage histogram.
// Input channel in_i carries one command item (move, decay, query, clear);
// output channel out_o carries one result item per query, none otherwise.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i;
// the user writes them only while the block is idle, which it does not enforce.
// One item is worked on at a time; in_i.ready is high only when idle.
// The single bin memory handles one bin a cycle: a first move wipes all
// NUM_BINS bins of the client, a move updates the bins of its span, a decay
// scales every bin, and a query walks to its start bin and then scans bins.
// A query's result sits in an output register; the next item is taken while
// it waits, and a later query only stalls at its last step until out_o is
// free. A stalled receiver never loses or repeats a result.
// Reset clears every client to uninitialized and the registers to their
// defaults; the bin memory is not cleared, a client's first move wipes its
// bins instead.
module histogram_delay_offset_estimator_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  hdoe_in_if.sink                   in_i,
  hdoe_out_if.source                out_o,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [hdoe_pkg::CFG_W-1:0] cfg_data_i
);
  import hdoe_pkg::*;

  localparam int DIV5_SH = 24;
  localparam int DIV5_M  = (1 << DIV5_SH) / 5 + 1;

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Span end in bins, (now - t + 200) / 2 clamped to 0..NUM_BINS
  function automatic logic [IDX_W-1:0] span_end(logic [TIME_W-1:0] now,
                                                logic [TIME_W-1:0] t);
    logic signed [32:0] x;
    logic [31:0]        h;
    x = $signed({2'b0, now}) - $signed({2'b0, t}) + 33'sd200;
    h = x[32:1];
    if (x < 0) return '0;
    else if (h > 32'(NUM_BINS)) return IDX_W'(NUM_BINS);
    else return h[IDX_W-1:0];
  endfunction

  // Configuration
  logic signed [10:0] user_off_q;
  logic [9:0]         max_shift_q, hold_ms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      user_off_q  <= '0;
      max_shift_q <= 10'd300;
      hold_ms_q   <= 10'd500;
    end else if (cfg_we_i) begin
      case (hdoe_cfg_e'(cfg_idx_i))
        CFG_USER_OFFSET: user_off_q  <= $signed(cfg_data_i[10:0]);
        CFG_MAX_SHIFT:   max_shift_q <= cfg_data_i[9:0];
        CFG_HOLD:        hold_ms_q   <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // Per-client scalar state
  logic [31:0]        tot_mem_q  [NUM_CLIENTS];
  logic [BIN_W-1:0]   sb_mem_q   [NUM_CLIENTS];
  logic [31:0]        tly_mem_q  [NUM_CLIENTS];
  logic signed [15:0] stab_mem_q [NUM_CLIENTS];
  logic [TIME_W-1:0]  lchk_mem_q [NUM_CLIENTS];
  logic [9:0]         hold_mem_q [NUM_CLIENTS];
  logic [NUM_CLIENTS-1:0] rdy_q;

  logic tot_we, sb_we, tly_we, stab_we, lchk_we, hold_we, rdy_set, rdy_clr;
  logic [31:0]        tot_wd, tly_wd;
  logic [BIN_W-1:0]   sb_wd;
  logic signed [15:0] stab_wd;
  logic [TIME_W-1:0]  lchk_wd;
  logic [9:0]         hold_wd;

  // Bin memory
  logic [CNT_W-1:0]  bin_mem [NUM_CLIENTS*NUM_BINS];
  logic [CNT_W-1:0]  rdata_q;
  logic              mem_re, mem_we;
  logic [ADDR_W-1:0] mem_raddr, mem_waddr;
  logic [CNT_W-1:0]  mem_wdata;

  // Control and working registers
  hdoe_state_e state_q, state_d;
  hdoe_cmd_e   cmd_q, cmd_d;
  logic        ok_q, ok_d;
  logic [CL_W-1:0]   cidx_q, cidx_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic [TIME_W-1:0] now_q, now_d, st_q, st_d, en_q, en_d, ct_q, ct_d;
  logic [IDX_W-1:0]  idx_q, idx_d, hi_q, hi_d;
  logic [BIN_W-1:0]  sb_q, sb_d, best_q, best_d, pidx_q, pidx_d;
  logic [31:0]       tally_q, tally_d, total_q, total_d;
  logic signed [43:0] best_num_q, best_num_d;
  logic        first_q, first_d, pv_q, pv_d;
  logic [41:0]        p1_q, p1_d;
  logic signed [42:0] p2_q, p2_d;
  logic signed [17:0] stab1_q, stab1_d;
  logic signed [36:0] cap_q, cap_d;
  logic signed [15:0] stab2_q, stab2_d;
  logic signed [11:0] res_off_q, res_off_d;
  logic signed [10:0] res_opt_q, res_opt_d;
  logic               res_act_q, res_act_d;
  logic               out_load;

  logic               out_valid_q;
  logic signed [11:0] out_off_q;
  logic signed [10:0] out_opt_q;
  logic               out_act_q;

  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    logic [CNT_W-1:0]   b, room, add, v;
    logic [CNT_W+1:0]   y;
    logic [CNT_W+23:0]  prod5;
    logic [IDX_W-1:0]   lo, hi;
    logic [33:0]        t4, tot3;
    logic [37:0]        t50, tot49;
    logic signed [11:0] off;
    logic signed [42:0] offx, totx;
    logic signed [43:0] num;
    logic signed [12:0] tgt;
    logic signed [17:0] t10, s;
    logic signed [32:0] dt;
    logic [6:0]         dl;
    logic signed [11:0] hdif;
    logic [9:0]         hnew;
    logic signed [36:0] cb, s2;
    logic signed [16:0] sx;
    logic [16:0]        a5;
    logic [33:0]        prq;
    logic [12:0]        q;
    logic signed [14:0] r;

    state_d = state_q;  cmd_d = cmd_q;  ok_d = ok_q;  cidx_d = cidx_q;
    base_d = base_q;  now_d = now_q;  st_d = st_q;  en_d = en_q;  ct_d = ct_q;
    idx_d = idx_q;  hi_d = hi_q;  sb_d = sb_q;  best_d = best_q;
    tally_d = tally_q;  total_d = total_q;  best_num_d = best_num_q;
    first_d = first_q;  pv_d = 1'b0;  p1_d = p1_q;  p2_d = p2_q;
    pidx_d = pidx_q;  stab1_d = stab1_q;  cap_d = cap_q;  stab2_d = stab2_q;
    res_off_d = res_off_q;  res_opt_d = res_opt_q;  res_act_d = res_act_q;
    out_load = 1'b0;

    tot_we = 1'b0;  sb_we = 1'b0;  tly_we = 1'b0;  stab_we = 1'b0;
    lchk_we = 1'b0;  hold_we = 1'b0;  rdy_set = 1'b0;  rdy_clr = 1'b0;
    tot_wd = total_d;  tly_wd = tally_q;  sb_wd = sb_q;  stab_wd = stab2_q;
    lchk_wd = now_q;  hold_wd = '0;

    mem_re = 1'b0;  mem_we = 1'b0;
    mem_raddr = base_q + ADDR_W'(idx_q);
    mem_waddr = base_q + ADDR_W'(idx_q);
    mem_wdata = '0;

    b = rdata_q;
    room = BIN_MAX - b;
    add = (room < BIN_ONE) ? room : BIN_ONE;
    y = {b, 2'b00};
    prod5 = (CNT_W+24)'(y) * (CNT_W+24)'(DIV5_M);
    v = prod5[DIV5_SH +: CNT_W];
    lo = span_end(now_q, en_q);
    hi = span_end(now_q, st_q);
    t4 = {tally_q, 2'b00};
    tot3 = 34'(total_q) * 34'd3;
    t50 = 38'(tally_q) * 38'd50;
    tot49 = 38'(total_q) * 38'd49;
    off = $signed(12'({idx_q, 1'b0})) - 12'sd200;
    offx = 43'(off);
    totx = $signed(43'(total_q));
    num = $signed({2'b00, p1_q}) - 44'(p2_q);

    tgt = $signed(13'({best_q, 1'b0})) - 13'sd200;
    t10 = 18'(tgt) * 18'sd10;
    dt = $signed({2'b0, now_q}) - $signed({2'b0, lchk_mem_q[cidx_q]});
    dl = (dt < 0) ? 7'd0 : ((dt > 33'sd100) ? 7'd100 : dt[6:0]);
    hdif = $signed({2'b0, hold_mem_q[cidx_q]}) - $signed({5'b0, dl});
    s = 18'(stab_mem_q[cidx_q]);
    hnew = hold_mem_q[cidx_q];
    cb = 37'($signed({2'b0, now_q}) - $signed({2'b0, ct_q}))
         + $signed({27'b0, max_shift_q});
    s2 = (37'(stab1_q) > cap_q) ? cap_q : 37'(stab1_q);
    sx = 17'(stab2_q);
    a5 = ((stab2_q < 0) ? 17'(-sx) : 17'(sx)) + 17'd5;
    prq = 34'(a5) * 34'd52429;
    q = prq[19 +: 13];
    r = ((stab2_q < 0) ? -15'(q) : 15'(q)) + 15'sd5 + 15'(user_off_q);

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          cmd_d  = hdoe_cmd_e'(in_i.cmd);
          ok_d   = (32'(in_i.client) < NUM_CLIENTS);
          cidx_d = in_i.client[CL_W-1:0];
          base_d = ADDR_W'(32'(in_i.client[CL_W-1:0]) * NUM_BINS);
          now_d  = in_i.time_now;
          st_d   = in_i.start_time;
          en_d   = in_i.end_time;
          ct_d   = in_i.command_time;
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        state_d = S_IDLE;
        case (cmd_q)
          CMD_QUERY: begin
            if (ok_q && rdy_q[cidx_q]) begin
              total_d = tot_mem_q[cidx_q];
              tally_d = tly_mem_q[cidx_q];
              sb_d = (sb_mem_q[cidx_q] > BIN_W'(NUM_BINS-1)) ?
                     BIN_W'(NUM_BINS-1) : sb_mem_q[cidx_q];
              state_d = S_BACK_PRIME;
            end else begin
              res_off_d = '0;  res_opt_d = '0;  res_act_d = 1'b0;
              state_d = S_OUT;
            end
          end
          CMD_MOVE: begin
            if (ok_q && !rdy_q[cidx_q]) begin
              // first move: wipe the client
              tot_we = 1'b1;  sb_we = 1'b1;  tly_we = 1'b1;  stab_we = 1'b1;
              lchk_we = 1'b1;  hold_we = 1'b1;  rdy_set = 1'b1;
              tot_wd = '0;  tly_wd = '0;  sb_wd = '0;  stab_wd = '0;
              lchk_wd = '0;  hold_wd = '0;
              idx_d = '0;
              state_d = S_WIPE;
            end else if (ok_q) begin
              total_d = tot_mem_q[cidx_q];
              tally_d = tly_mem_q[cidx_q];
              sb_d = sb_mem_q[cidx_q];
              idx_d = lo;
              hi_d = (hi < lo) ? lo : hi;
              if (hi > lo) state_d = S_MOVE_PRIME;
            end
          end
          CMD_DECAY: begin
            if (ok_q) begin
              idx_d = '0;
              total_d = '0;
              state_d = S_DECAY_PRIME;
            end
          end
          CMD_CLEAR: rdy_clr = ok_q;
          default: ;
        endcase
      end
      S_WIPE: begin
        mem_we = 1'b1;
        mem_wdata = '0;
        idx_d = idx_q + 1'b1;
        if (idx_q == IDX_W'(NUM_BINS-1)) state_d = S_IDLE;
      end
      S_MOVE_PRIME: begin
        mem_re = 1'b1;
        state_d = S_MOVE;
      end
      S_MOVE: begin
        // read-modify-write one bin, next read already issued
        mem_we = 1'b1;
        mem_wdata = b + add;
        total_d = sat_add(total_q, 32'(add));
        if (idx_q <= IDX_W'(sb_q)) tally_d = sat_add(tally_q, 32'(add));
        if (idx_q + 1'b1 < hi_q) begin
          idx_d = idx_q + 1'b1;
          mem_re = 1'b1;
          mem_raddr = base_q + ADDR_W'(idx_q) + ADDR_W'(1);
        end else begin
          tot_we = 1'b1;  tly_we = 1'b1;
          tot_wd = total_d;  tly_wd = tally_d;
          state_d = S_IDLE;
        end
      end
      S_DECAY_PRIME: begin
        mem_re = 1'b1;
        state_d = S_DECAY;
      end
      S_DECAY: begin
        mem_we = 1'b1;
        mem_wdata = v;
        total_d = sat_add(total_q, 32'(v));
        if (idx_q == IDX_W'(NUM_BINS-1)) begin
          tot_we = 1'b1;  sb_we = 1'b1;  tly_we = 1'b1;
          tot_wd = total_d;  sb_wd = '0;  tly_wd = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
          mem_re = 1'b1;
          mem_raddr = base_q + ADDR_W'(idx_q) + ADDR_W'(1);
        end
      end
      S_BACK_PRIME: begin
        mem_re = 1'b1;
        mem_raddr = base_q + ADDR_W'(sb_q);
        state_d = S_BACK;
      end
      S_BACK: begin
        // walk down while coverage above 75%; rdata holds bin[sb]
        if (sb_q != '0 && t4 > tot3) begin
          tally_d = (tally_q > 32'(b)) ? tally_q - 32'(b) : '0;
          sb_d = sb_q - 1'b1;
          mem_re = 1'b1;
          mem_raddr = base_q + ADDR_W'(sb_q) - ADDR_W'(1);
        end else begin
          state_d = S_FWD_PRIME;
        end
      end
      S_FWD_PRIME: begin
        mem_re = (int'(sb_q) < NUM_BINS - 1);
        mem_raddr = base_q + ADDR_W'(sb_q) + ADDR_W'(1);
        state_d = S_FWD;
      end
      S_FWD: begin
        // walk up while coverage below 75%; rdata holds bin[sb+1]
        if (int'(sb_q) < NUM_BINS - 1 && t4 < tot3) begin
          sb_d = sb_q + 1'b1;
          tally_d = sat_add(tally_q, 32'(b));
          mem_re = (int'(sb_q) + 2 <= NUM_BINS - 1);
          mem_raddr = base_q + ADDR_W'(sb_q) + ADDR_W'(2);
        end else begin
          sb_we = 1'b1;  tly_we = 1'b1;
          sb_wd = sb_q;  tly_wd = tally_q;
          best_d = sb_q;
          idx_d = IDX_W'(sb_q);
          first_d = 1'b1;
          state_d = (total_q == '0) ? S_FIN1 : S_SCAN_PRIME;
        end
      end
      S_SCAN_PRIME: begin
        mem_re = (int'(idx_q) < NUM_BINS - 1);
        mem_raddr = base_q + ADDR_W'(idx_q) + ADDR_W'(1);
        state_d = S_SCAN;
      end
      S_SCAN: begin
        // products for this bin go to the compare stage
        pv_d = 1'b1;
        p1_d = 42'(tally_q) * 42'd1000;
        p2_d = offx * totx;
        pidx_d = idx_q[BIN_W-1:0];
        if (t50 > tot49 || int'(idx_q) == NUM_BINS - 1) begin
          state_d = S_DRAIN;
        end else begin
          tally_d = sat_add(tally_q, 32'(b));
          idx_d = idx_q + 1'b1;
          mem_re = (int'(idx_q) + 2 <= NUM_BINS - 1);
          mem_raddr = base_q + ADDR_W'(idx_q) + ADDR_W'(2);
        end
      end
      S_DRAIN: state_d = S_FIN1;
      S_FIN1: begin
        // slew toward target, hold before a decrease
        if (t10 > s) begin
          s = s + $signed({11'b0, dl}) * 18'sd5;
          if (s > t10) s = t10;
          hnew = hold_ms_q;
        end else if (t10 < s) begin
          if (hdif < 0) begin
            s = s + 18'(hdif);
            hnew = '0;
            if (s < t10) s = t10;
          end else begin
            hnew = hdif[9:0];
          end
        end
        stab1_d = s;
        cap_d = cb * 37'sd10;
        hold_we = 1'b1;  hold_wd = hnew;
        lchk_we = 1'b1;  lchk_wd = now_q;
        res_opt_d = tgt[10:0];
        state_d = S_FIN2;
      end
      S_FIN2: begin
        // cap above client lag, then saturate to 16 bits
        if (s2 > 37'sd32767) stab2_d = 16'sd32767;
        else if (s2 < -37'sd32768) stab2_d = -16'sd32768;
        else stab2_d = s2[15:0];
        stab_we = 1'b1;
        stab_wd = stab2_d;
        state_d = S_FIN3;
      end
      S_FIN3: begin
        // round half away from zero, add fixed and user offset
        if (r > 15'sd2047) res_off_d = 12'sd2047;
        else if (r < -15'sd2048) res_off_d = -12'sd2048;
        else res_off_d = r[11:0];
        res_act_d = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // compare stage of the scan
    if (pv_q && (first_q || num > best_num_q)) begin
      best_d = pidx_q;
      best_num_d = num;
      first_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pv_q    <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;  ok_q <= ok_d;  cidx_q <= cidx_d;  base_q <= base_d;
    now_q <= now_d;  st_q <= st_d;  en_q <= en_d;  ct_q <= ct_d;
    idx_q <= idx_d;  hi_q <= hi_d;  sb_q <= sb_d;  best_q <= best_d;
    tally_q <= tally_d;  total_q <= total_d;  best_num_q <= best_num_d;
    first_q <= first_d;  p1_q <= p1_d;  p2_q <= p2_d;  pidx_q <= pidx_d;
    stab1_q <= stab1_d;  cap_q <= cap_d;  stab2_q <= stab2_d;
    res_off_q <= res_off_d;  res_opt_q <= res_opt_d;  res_act_q <= res_act_d;
  end

  // Per-client state writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdy_q <= '0;
      for (int i = 0; i < NUM_CLIENTS; i++) begin
        tot_mem_q[i]  <= '0;
        sb_mem_q[i]   <= '0;
        tly_mem_q[i]  <= '0;
        stab_mem_q[i] <= '0;
        lchk_mem_q[i] <= '0;
        hold_mem_q[i] <= '0;
      end
    end else begin
      if (tot_we)  tot_mem_q[cidx_q]  <= tot_wd;
      if (sb_we)   sb_mem_q[cidx_q]   <= sb_wd;
      if (tly_we)  tly_mem_q[cidx_q]  <= tly_wd;
      if (stab_we) stab_mem_q[cidx_q] <= stab_wd;
      if (lchk_we) lchk_mem_q[cidx_q] <= lchk_wd;
      if (hold_we) hold_mem_q[cidx_q] <= hold_wd;
      if (rdy_set) rdy_q[cidx_q] <= 1'b1;
      if (rdy_clr) rdy_q[cidx_q] <= 1'b0;
    end
  end

  // Bin memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) bin_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= bin_mem[mem_raddr];
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_off_q <= res_off_q;
      out_opt_q <= res_opt_q;
      out_act_q <= res_act_q;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.offset_ms         = out_off_q;
  assign out_o.optimal_offset_ms = out_opt_q;
  assign out_o.active            = out_act_q;

endmodule

### rtl/hdoe_checker.sv
`include "histogram_delay_offset_estimator_top_defines.svh"

module hdoe_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [11:0] offset_ms,
  input logic signed [10:0] optimal_offset_ms,
  input logic               active
);

  // no result shown while in reset
  `HDOE_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !out_valid, "result valid during reset")

  // a stalled result stays and holds its payload
  `HDOE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped")
  `HDOE_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(offset_ms) && $stable(optimal_offset_ms) && $stable(active), "result changed under stall")

  // an inactive client gives all-zero fields
  `HDOE_ASSERT(a_idle_zero, out_valid && !active |-> offset_ms == 12'sd0 && optimal_offset_ms == 11'sd0, "inactive result not zero")

  // one item at a time: busy right after an accept
  `HDOE_ASSERT(a_busy, in_valid && in_ready |=> !in_ready, "second item taken while busy")

endmodule

bind histogram_delay_offset_estimator_top hdoe_checker u_hdoe_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid          (in_i.valid),
  .in_ready          (in_i.ready),
  .out_valid         (out_o.valid),
  .out_ready         (out_o.ready),
  .offset_ms         (out_o.offset_ms),
  .optimal_offset_ms (out_o.optimal_offset_ms),
  .active            (out_o.active)
);
